>>> src/vna_pkg.sv
// Shared types and constants for the vertex normal accumulator.
package vna_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned IDX_W = 10;
  localparam int unsigned POS_W = 16;
  localparam int unsigned NRM_W = 16;

  // Width of a vector entering normalization (a cross product needs 34 bits).
  localparam int unsigned VEC_W = 35;

  // Action codes carried on the action field.
  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_READ  = 2'd3
  } action_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TRI_RD,
    ST_CROSS,
    ST_ACC_RD,
    ST_ACC_WAIT,
    ST_NRM_LOAD,
    ST_NRM_SHIFT,
    ST_NRM_SQ,
    ST_NRM_SQRT,
    ST_DIV_INIT,
    ST_DIV,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_OUT
  } state_e;

endpackage

>>> src/vertex_normal_accumulator_unit.sv
// Vertex normal accumulator: vertex store, accumulators and a shared normalizer.
// Write vertex and clear act on acceptance. A read loads the accumulator and normalizes it
// by one-bit scaling shifts, squaring, square root and division; a zero vector skips these.
// Add triangle reads the three corners, forms the cross product, normalizes it (skipped for
// a zero normal) and updates the three corner accumulators; one item at a time.
// Reset zeroes the accumulators in a sweep over all VERTEX_DEPTH entries with the input stalled.
module vertex_normal_accumulator_unit #(
  parameter int unsigned VERTEX_DEPTH = 1024,
  parameter int unsigned ACCUM_WIDTH  = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        action_i,
  input  logic [vna_pkg::IDX_W-1:0]         index_i,
  input  logic [vna_pkg::IDX_W-1:0]         corner_b_i,
  input  logic [vna_pkg::IDX_W-1:0]         corner_c_i,
  input  logic signed [vna_pkg::POS_W-1:0]  coord_x_i,
  input  logic signed [vna_pkg::POS_W-1:0]  coord_y_i,
  input  logic signed [vna_pkg::POS_W-1:0]  coord_z_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [vna_pkg::IDX_W-1:0]         vertex_index_o,
  output logic signed [vna_pkg::NRM_W-1:0]  normal_x_o,
  output logic signed [vna_pkg::NRM_W-1:0]  normal_y_o,
  output logic signed [vna_pkg::NRM_W-1:0]  normal_z_o,
  output logic                              degenerate_o
);

  localparam int unsigned AW    = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
  localparam int unsigned VEC_W = vna_pkg::VEC_W;
  localparam int unsigned POS_W = vna_pkg::POS_W;
  localparam int unsigned NRM_W = vna_pkg::NRM_W;
  localparam int unsigned IDX_W = vna_pkg::IDX_W;

  vna_pkg::state_e state_q, state_d;

  // Memories.
  logic [3*POS_W-1:0]       vert_mem [VERTEX_DEPTH];
  logic [3*ACCUM_WIDTH-1:0] acc_mem  [VERTEX_DEPTH];
  logic [3*POS_W-1:0]       vert_rdata_q;
  logic [3*ACCUM_WIDTH-1:0] acc_rdata_q;
  logic                     vert_we;
  logic [AW-1:0]            vert_waddr, vert_raddr;
  logic                     acc_we;
  logic [AW-1:0]            acc_waddr, acc_raddr;
  logic [3*ACCUM_WIDTH-1:0] acc_wdata;

  // Item registers.
  logic [1:0]       act_q;
  logic [IDX_W-1:0] ia_q, ib_q, ic_q;
  logic             ia_ok_q;
  logic [AW-1:0]    clr_addr_q;
  logic [4:0]       step_q;
  logic [1:0]       comp_q;

  // Datapath registers.
  logic signed [POS_W-1:0] pa_q [3];
  logic signed [POS_W-1:0] pb_q [3];
  logic signed [POS_W-1:0] pc_q [3];
  logic signed [VEC_W-1:0] v_q [3];
  logic [VEC_W-1:0]        m_q [3];
  logic                    sgn_q [3];
  logic [VEC_W-1:0]        mx_q;
  logic [63:0]             s_q, res_q, bit_q;
  logic [32:0]             div_rem_q;
  logic [14:0]             div_low_q, quo_q;
  logic signed [NRM_W-1:0] n_q [3];
  logic                    deg_q;

  // Output register.
  logic                    out_valid_q;
  logic [IDX_W-1:0]        vertex_index_q;
  logic signed [NRM_W-1:0] normal_x_q, normal_y_q, normal_z_q;
  logic                    degenerate_q;
  logic                    out_load;

  // Input decode.
  logic in_accept;
  logic a_ok, b_ok, c_ok;

  assign in_stall_o = (state_q != vna_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign a_ok       = (32'(index_i) < VERTEX_DEPTH);
  assign b_ok       = (32'(corner_b_i) < VERTEX_DEPTH);
  assign c_ok       = (32'(corner_c_i) < VERTEX_DEPTH);

  // Saturating add of a normal component into an accumulator component.
  function automatic logic [ACCUM_WIDTH-1:0] sat_add(input logic [ACCUM_WIDTH-1:0] a,
                                                     input logic [NRM_W-1:0] b);
    logic [ACCUM_WIDTH:0] s;
    s = {a[ACCUM_WIDTH-1], a} + {{(ACCUM_WIDTH+1-NRM_W){b[NRM_W-1]}}, b};
    if (s[ACCUM_WIDTH] != s[ACCUM_WIDTH-1]) begin
      sat_add = s[ACCUM_WIDTH] ? {1'b1, {(ACCUM_WIDTH-1){1'b0}}}
                               : {1'b0, {(ACCUM_WIDTH-1){1'b1}}};
    end else begin
      sat_add = s[ACCUM_WIDTH-1:0];
    end
  endfunction

  // Edge vectors about the second corner.
  logic signed [POS_W:0] e1 [3];
  logic signed [POS_W:0] e2 [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e1[k] = (POS_W+1)'(pa_q[k]) - (POS_W+1)'(pb_q[k]);
      e2[k] = (POS_W+1)'(pc_q[k]) - (POS_W+1)'(pb_q[k]);
    end
  end

  // The shared multiplier: cross product terms, then squared magnitudes.
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == vna_pkg::ST_CROSS) begin
      case (step_q[2:0])
        3'd0: begin mul_a = 32'(e1[1]); mul_b = 32'(e2[2]); end
        3'd1: begin mul_a = 32'(e1[2]); mul_b = 32'(e2[1]); end
        3'd2: begin mul_a = 32'(e1[2]); mul_b = 32'(e2[0]); end
        3'd3: begin mul_a = 32'(e1[0]); mul_b = 32'(e2[2]); end
        3'd4: begin mul_a = 32'(e1[0]); mul_b = 32'(e2[1]); end
        3'd5: begin mul_a = 32'(e1[1]); mul_b = 32'(e2[0]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (step_q[1:0] != 2'd3) begin
      mul_a = $signed({1'b0, m_q[step_q[1:0]][30:0]});
      mul_b = mul_a;
    end
  end
  assign prod = mul_a * mul_b;

  // Largest magnitude when a vector is loaded.
  logic [VEC_W-1:0] mag [3];
  logic [VEC_W-1:0] mag_max;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k] = v_q[k][VEC_W-1] ? VEC_W'(-v_q[k]) : VEC_W'(v_q[k]);
    end
    mag_max = (mag[0] > mag[1]) ? mag[0] : mag[1];
    if (mag[2] > mag_max) mag_max = mag[2];
  end

  // Square root step.
  logic [63:0] sq_t;
  logic        sq_ge;
  assign sq_t  = res_q + bit_q;
  assign sq_ge = (s_q >= sq_t);

  // Division setup and step: (m * 16384 + L/2) / L.
  logic [45:0] div_num;
  logic [33:0] div_t;
  logic        div_ge;
  logic [14:0] quo_next;
  assign div_num  = {m_q[comp_q][30:0], 14'd0} + 46'(res_q[31:1]);
  assign div_t    = {div_rem_q, div_low_q[14]};
  assign div_ge   = (div_t >= {2'b00, res_q[31:0]});
  assign quo_next = {quo_q[13:0], div_ge};

  // Accumulator components from the read port.
  logic [ACCUM_WIDTH-1:0] acc_cur [3];
  always_comb begin
    acc_cur[0] = acc_rdata_q[3*ACCUM_WIDTH-1:2*ACCUM_WIDTH];
    acc_cur[1] = acc_rdata_q[2*ACCUM_WIDTH-1:ACCUM_WIDTH];
    acc_cur[2] = acc_rdata_q[ACCUM_WIDTH-1:0];
  end

  logic [IDX_W-1:0] upd_idx;
  always_comb begin
    case (comp_q)
      2'd0:    upd_idx = ia_q;
      2'd1:    upd_idx = ib_q;
      default: upd_idx = ic_q;
    endcase
  end

  // Sequencer: next state and memory controls.
  always_comb begin
    state_d    = state_q;
    vert_we    = 1'b0;
    vert_waddr = AW'(index_i);
    acc_we     = 1'b0;
    acc_waddr  = AW'(index_i);
    acc_wdata  = '0;
    acc_raddr  = AW'(ia_q);
    out_load   = 1'b0;
    case (step_q[1:0])
      2'd0:    vert_raddr = AW'(ia_q);
      2'd1:    vert_raddr = AW'(ib_q);
      default: vert_raddr = AW'(ic_q);
    endcase
    case (state_q)
      vna_pkg::ST_CLEAR: begin
        acc_we    = 1'b1;
        acc_waddr = clr_addr_q;
        if (clr_addr_q == AW'(VERTEX_DEPTH - 1)) state_d = vna_pkg::ST_IDLE;
      end
      vna_pkg::ST_IDLE: begin
        if (in_accept) begin
          case (action_i)
            vna_pkg::ACT_WRITE: vert_we = a_ok;
            vna_pkg::ACT_ADD: begin
              if (a_ok && b_ok && c_ok) state_d = vna_pkg::ST_TRI_RD;
            end
            vna_pkg::ACT_CLEAR: acc_we = a_ok;
            default: state_d = vna_pkg::ST_ACC_RD;
          endcase
        end
      end
      vna_pkg::ST_TRI_RD: begin
        if (step_q == 5'd3) state_d = vna_pkg::ST_CROSS;
      end
      vna_pkg::ST_CROSS: begin
        if (step_q == 5'd5) state_d = vna_pkg::ST_NRM_LOAD;
      end
      vna_pkg::ST_ACC_RD:   state_d = vna_pkg::ST_ACC_WAIT;
      vna_pkg::ST_ACC_WAIT: state_d = vna_pkg::ST_NRM_LOAD;
      vna_pkg::ST_NRM_LOAD: begin
        if (mag_max == '0) begin
          state_d = (act_q == vna_pkg::ACT_READ) ? vna_pkg::ST_OUT : vna_pkg::ST_UPD_RD;
        end else begin
          state_d = vna_pkg::ST_NRM_SHIFT;
        end
      end
      vna_pkg::ST_NRM_SHIFT: begin
        if (mx_q >= VEC_W'(64'd1 << 30) && mx_q < VEC_W'(64'd1 << 31)) begin
          state_d = vna_pkg::ST_NRM_SQ;
        end
      end
      vna_pkg::ST_NRM_SQ: begin
        if (step_q == 5'd2) state_d = vna_pkg::ST_NRM_SQRT;
      end
      vna_pkg::ST_NRM_SQRT: begin
        if (bit_q == 64'd1) state_d = vna_pkg::ST_DIV_INIT;
      end
      vna_pkg::ST_DIV_INIT: state_d = vna_pkg::ST_DIV;
      vna_pkg::ST_DIV: begin
        if (step_q == 5'd14) begin
          if (comp_q != 2'd2) begin
            state_d = vna_pkg::ST_DIV_INIT;
          end else begin
            state_d = (act_q == vna_pkg::ACT_READ) ? vna_pkg::ST_OUT : vna_pkg::ST_UPD_RD;
          end
        end
      end
      vna_pkg::ST_UPD_RD: begin
        acc_raddr = AW'(upd_idx);
        state_d   = vna_pkg::ST_UPD_WR;
      end
      vna_pkg::ST_UPD_WR: begin
        acc_we    = 1'b1;
        acc_waddr = AW'(upd_idx);
        acc_wdata = {sat_add(acc_cur[0], n_q[0]), sat_add(acc_cur[1], n_q[1]),
                     sat_add(acc_cur[2], n_q[2])};
        state_d   = (comp_q == 2'd2) ? vna_pkg::ST_IDLE : vna_pkg::ST_UPD_RD;
      end
      vna_pkg::ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = vna_pkg::ST_IDLE;
        end
      end
      default: state_d = vna_pkg::ST_IDLE;
    endcase
  end

  // State register and clearing sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= vna_pkg::ST_CLEAR;
      clr_addr_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == vna_pkg::ST_CLEAR) clr_addr_q <= clr_addr_q + AW'(1);
    end
  end

  // Vertex store.
  always_ff @(posedge clk_i) begin
    if (vert_we) vert_mem[vert_waddr] <= {coord_x_i, coord_y_i, coord_z_i};
    vert_rdata_q <= vert_mem[vert_raddr];
  end

  // Accumulator store.
  always_ff @(posedge clk_i) begin
    if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
    acc_rdata_q <= acc_mem[acc_raddr];
  end

  // Datapath sequencing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      comp_q <= '0;
    end else begin
      case (state_q)
        vna_pkg::ST_IDLE: begin
          step_q <= '0;
          comp_q <= '0;
        end
        vna_pkg::ST_TRI_RD, vna_pkg::ST_CROSS, vna_pkg::ST_NRM_SQ: begin
          step_q <= (state_d == state_q) ? step_q + 5'd1 : 5'd0;
        end
        vna_pkg::ST_NRM_LOAD: begin
          step_q <= '0;
          comp_q <= '0;
        end
        vna_pkg::ST_NRM_SHIFT, vna_pkg::ST_NRM_SQRT, vna_pkg::ST_DIV_INIT: begin
          step_q <= '0;
        end
        vna_pkg::ST_DIV: begin
          if (step_q == 5'd14) begin
            step_q <= '0;
            comp_q <= (comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1;
          end else begin
            step_q <= step_q + 5'd1;
          end
        end
        vna_pkg::ST_UPD_WR: comp_q <= comp_q + 2'd1;
        default: begin
          step_q <= step_q;
          comp_q <= comp_q;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      vna_pkg::ST_IDLE: begin
        act_q   <= action_i;
        ia_q    <= index_i;
        ib_q    <= corner_b_i;
        ic_q    <= corner_c_i;
        ia_ok_q <= a_ok;
      end
      vna_pkg::ST_TRI_RD: begin
        for (int k = 0; k < 3; k++) begin
          case (step_q[1:0])
            2'd1: pa_q[k] <= vert_rdata_q[(3-k)*POS_W-1 -: POS_W];
            2'd2: pb_q[k] <= vert_rdata_q[(3-k)*POS_W-1 -: POS_W];
            2'd3: pc_q[k] <= vert_rdata_q[(3-k)*POS_W-1 -: POS_W];
            default: pa_q[k] <= pa_q[k];
          endcase
        end
      end
      vna_pkg::ST_CROSS: begin
        // Even steps load the first term, odd steps subtract the second.
        if (step_q[0]) v_q[step_q[2:1]] <= v_q[step_q[2:1]] - VEC_W'(prod);
        else           v_q[step_q[2:1]] <= VEC_W'(prod);
      end
      vna_pkg::ST_ACC_WAIT: begin
        for (int k = 0; k < 3; k++) begin
          v_q[k] <= ia_ok_q ? VEC_W'($signed(acc_cur[k])) : '0;
        end
      end
      vna_pkg::ST_NRM_LOAD: begin
        for (int k = 0; k < 3; k++) begin
          m_q[k]   <= mag[k];
          sgn_q[k] <= v_q[k][VEC_W-1];
          n_q[k]   <= '0;
        end
        mx_q  <= mag_max;
        deg_q <= (mag_max == '0);
        s_q   <= '0;
      end
      vna_pkg::ST_NRM_SHIFT: begin
        // Scale all magnitudes together until the largest is in [2^30, 2^31).
        if (mx_q < VEC_W'(64'd1 << 30)) begin
          mx_q <= mx_q << 1;
          for (int k = 0; k < 3; k++) m_q[k] <= m_q[k] << 1;
        end else if (mx_q >= VEC_W'(64'd1 << 31)) begin
          mx_q <= mx_q >> 1;
          for (int k = 0; k < 3; k++) m_q[k] <= m_q[k] >> 1;
        end
        res_q <= '0;
        bit_q <= 64'd1 << 62;
      end
      vna_pkg::ST_NRM_SQ: begin
        s_q <= s_q + 64'(prod);
      end
      vna_pkg::ST_NRM_SQRT: begin
        if (sq_ge) begin
          s_q   <= s_q - sq_t;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      vna_pkg::ST_DIV_INIT: begin
        div_rem_q <= 33'(div_num[45:15]);
        div_low_q <= div_num[14:0];
        quo_q     <= '0;
      end
      vna_pkg::ST_DIV: begin
        div_rem_q <= div_ge ? 33'(div_t - {2'b00, res_q[31:0]}) : div_t[32:0];
        div_low_q <= div_low_q << 1;
        quo_q     <= quo_next;
        if (step_q == 5'd14) begin
          n_q[comp_q] <= sgn_q[comp_q] ? -NRM_W'(quo_next) : NRM_W'(quo_next);
        end
      end
      default: begin
        act_q <= act_q;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      vertex_index_q <= ia_q;
      normal_x_q     <= n_q[0];
      normal_y_q     <= n_q[1];
      normal_z_q     <= n_q[2];
      degenerate_q   <= deg_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign vertex_index_o = vertex_index_q;
  assign normal_x_o     = normal_x_q;
  assign normal_y_o     = normal_y_q;
  assign normal_z_o     = normal_z_q;
  assign degenerate_o   = degenerate_q;

endmodule

>>> sim/vertex_normal_accumulator_unit_tb.sv
// Testbench for the vertex normal accumulator: directed and random beats checked against a predictor.
`timescale 1ns / 100ps

module vertex_normal_accumulator_unit_tb;

  localparam int DEPTH = 1024;
  localparam int ACC_W = 24;
  localparam longint ACC_HI = (64'sd1 <<< (ACC_W - 1)) - 1;
  localparam longint ACC_LO = -(64'sd1 <<< (ACC_W - 1));
  localparam int CYCLE_LIMIT = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] action_i = '0;
  logic [vna_pkg::IDX_W-1:0] index_i = '0;
  logic [vna_pkg::IDX_W-1:0] corner_b_i = '0;
  logic [vna_pkg::IDX_W-1:0] corner_c_i = '0;
  logic signed [vna_pkg::POS_W-1:0] coord_x_i = '0;
  logic signed [vna_pkg::POS_W-1:0] coord_y_i = '0;
  logic signed [vna_pkg::POS_W-1:0] coord_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [vna_pkg::IDX_W-1:0] vertex_index_o;
  logic signed [vna_pkg::NRM_W-1:0] normal_x_o;
  logic signed [vna_pkg::NRM_W-1:0] normal_y_o;
  logic signed [vna_pkg::NRM_W-1:0] normal_z_o;
  logic degenerate_o;

  typedef struct packed {
    logic [vna_pkg::IDX_W-1:0] idx;
    logic signed [vna_pkg::NRM_W-1:0] nx;
    logic signed [vna_pkg::NRM_W-1:0] ny;
    logic signed [vna_pkg::NRM_W-1:0] nz;
    logic deg;
  } normal_t;

  vertex_normal_accumulator_unit u_top (.*);

  // Predictor state.
  logic signed [vna_pkg::POS_W-1:0] pos_mem [DEPTH][3];
  longint acc_mem [DEPTH][3];
  bit written [DEPTH];
  normal_t normals_due [$];
  int errors = 0;
  longint cycles = 0;
  bit hold_off = 1'b0;

  initial forever #1 clk_i = ~clk_i;

  // Timeout watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** vertex_normal_accumulator_unit: FAILED **");
      $finish;
    end
  end

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch %s: got %0d want %0d", what, got, want);
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned s);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Scales the vector, then divides each magnitude by the length; returns 1 for zero.
  function automatic bit unit_vector(input longint v[3], output int n[3]);
    longint unsigned m[3], mx, s, len;
    mx = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = v[i] < 0 ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      n = '{0, 0, 0};
      return 1'b1;
    end
    while (mx < (64'd1 << 30)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    while (mx >= (64'd1 << 31)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    for (int i = 0; i < 3; i++) s += m[i] * m[i];
    len = int_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      n[i] = int'((m[i] * 16384 + len / 2) / len);
      if (v[i] < 0) n[i] = -n[i];
    end
    return 1'b0;
  endfunction

  function automatic longint sat_sum(input longint a, input longint b);
    longint r;
    r = a + b;
    if (r > ACC_HI) r = ACC_HI;
    if (r < ACC_LO) r = ACC_LO;
    return r;
  endfunction

  // Updates the predictor for one accepted beat.
  task automatic predict_beat(input vna_pkg::action_e act, input int a, input int b,
                              input int c, input logic signed [vna_pkg::POS_W-1:0] x,
                              input logic signed [vna_pkg::POS_W-1:0] y,
                              input logic signed [vna_pkg::POS_W-1:0] z);
    longint e1[3], e2[3], cr[3], v[3];
    int n[3];
    bit dg;
    normal_t r;
    case (act)
      vna_pkg::ACT_WRITE: begin
        pos_mem[a] = '{x, y, z};
        written[a] = 1'b1;
      end
      vna_pkg::ACT_ADD: begin
        for (int i = 0; i < 3; i++) begin
          e1[i] = longint'(pos_mem[a][i]) - longint'(pos_mem[b][i]);
          e2[i] = longint'(pos_mem[c][i]) - longint'(pos_mem[b][i]);
        end
        cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
        cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
        cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
        dg = unit_vector(cr, n);
        for (int i = 0; i < 3; i++) begin
          acc_mem[a][i] = sat_sum(acc_mem[a][i], n[i]);
          acc_mem[b][i] = sat_sum(acc_mem[b][i], n[i]);
          acc_mem[c][i] = sat_sum(acc_mem[c][i], n[i]);
        end
      end
      vna_pkg::ACT_CLEAR: acc_mem[a] = '{0, 0, 0};
      default: begin
        v = acc_mem[a];
        r.deg = unit_vector(v, n);
        r.idx = a[vna_pkg::IDX_W-1:0];
        r.nx = n[0][vna_pkg::NRM_W-1:0];
        r.ny = n[1][vna_pkg::NRM_W-1:0];
        r.nz = n[2][vna_pkg::NRM_W-1:0];
        normals_due = {normals_due, r};
      end
    endcase
  endtask

  // Sends one beat, holding it until accepted, then predicts it.
  task automatic send_beat(input vna_pkg::action_e act, input int a, input int b,
                           input int c, input logic signed [vna_pkg::POS_W-1:0] x,
                           input logic signed [vna_pkg::POS_W-1:0] y,
                           input logic signed [vna_pkg::POS_W-1:0] z);
    in_valid_i <= 1'b1;
    action_i <= act;
    index_i <= a[vna_pkg::IDX_W-1:0];
    corner_b_i <= b[vna_pkg::IDX_W-1:0];
    corner_c_i <= c[vna_pkg::IDX_W-1:0];
    coord_x_i <= x;
    coord_y_i <= y;
    coord_z_i <= z;
    do @(posedge clk_i); while (in_stall_o);
    predict_beat(act, a, b, c, x, y, z);
    @(negedge clk_i);
  endtask

  task automatic idle_gap(input int n);
    in_valid_i <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // Random gap after roughly each burst of beats.
  int burst_left = 0;
  task automatic pace();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 40));
    end
    burst_left--;
  endtask

  function automatic logic signed [vna_pkg::POS_W-1:0] rnd_pos();
    return $urandom_range(0, 3) == 0 ? vna_pkg::POS_W'($urandom)
                                     : vna_pkg::POS_W'($signed($urandom_range(0, 4095)) - 2048);
  endfunction

  function automatic int rnd_written();
    int k;
    do k = $urandom_range(0, DEPTH - 1); while (!written[k]);
    return k;
  endfunction

  // Receiver stall pattern with an occasional long hold-off.
  initial begin
    int mode;
    forever begin
      @(negedge clk_i);
      if (hold_off) out_stall_i <= 1'b1;
      else begin
        mode = $urandom_range(0, 3);
        out_stall_i <= (mode == 0) ? 1'b0 : ($urandom_range(0, 3) < mode);
      end
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    normal_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (normals_due.size() == 0) begin
        report("unexpected normal for vertex", vertex_index_o, -1);
      end else begin
        w = normals_due.pop_front();
        if (vertex_index_o !== w.idx) report("vertex_index", vertex_index_o, w.idx);
        if (normal_x_o !== w.nx) report("normal_x", normal_x_o, w.nx);
        if (normal_y_o !== w.ny) report("normal_y", normal_y_o, w.ny);
        if (normal_z_o !== w.nz) report("normal_z", normal_z_o, w.nz);
        if (degenerate_o !== w.deg) report("degenerate", degenerate_o, w.deg);
      end
    end
  end

  // Directed: extremes, every action and degenerate cases.
  task automatic test_directed();
    send_beat(vna_pkg::ACT_READ, 0, 0, 0, 0, 0, 0);
    send_beat(vna_pkg::ACT_WRITE, 0, 0, 0, 0, 0, 0);
    send_beat(vna_pkg::ACT_WRITE, 1, 0, 0, 16'sh0100, 0, 0);
    send_beat(vna_pkg::ACT_WRITE, 2, 0, 0, 0, 16'sh0100, 0);
    send_beat(vna_pkg::ACT_ADD, 1, 0, 2, 0, 0, 0);
    send_beat(vna_pkg::ACT_READ, 1, 0, 0, 0, 0, 0);
    send_beat(vna_pkg::ACT_ADD, 1, 1, 2, 0, 0, 0);
    send_beat(vna_pkg::ACT_READ, 2, 0, 0, 0, 0, 0);
    send_beat(vna_pkg::ACT_WRITE, 1023, 0, 0, 16'sh7fff, -16'sh8000, 16'sh7fff);
    send_beat(vna_pkg::ACT_WRITE, 1022, 0, 0, -16'sh8000, 16'sh7fff, -16'sh8000);
    send_beat(vna_pkg::ACT_WRITE, 1021, 0, 0, 16'sh7fff, 16'sh7fff, -16'sh8000);
    send_beat(vna_pkg::ACT_ADD, 1023, 1022, 1021, 0, 0, 0);
    send_beat(vna_pkg::ACT_READ, 1023, 0, 0, 0, 0, 0);
    send_beat(vna_pkg::ACT_WRITE, 3, 0, 0, 16'sh0100, 16'sh0100, 0);
    send_beat(vna_pkg::ACT_ADD, 1, 3, 2, 0, 0, 0);
    send_beat(vna_pkg::ACT_READ, 3, 0, 0, 0, 0, 0);
    send_beat(vna_pkg::ACT_CLEAR, 1, 0, 0, 0, 0, 0);
    send_beat(vna_pkg::ACT_READ, 1, 0, 0, 0, 0, 0);
    send_beat(vna_pkg::ACT_CLEAR, 1023, 0, 0, 0, 0, 0);
    send_beat(vna_pkg::ACT_READ, 1023, 0, 0, 0, 0, 0);
    idle_gap(1);
  endtask

  // Saturation: many identical triangles on the same three vertices.
  task automatic test_saturation();
    for (int i = 0; i < 600; i++) send_beat(vna_pkg::ACT_ADD, 1, 0, 2, 0, 0, 0);
    send_beat(vna_pkg::ACT_READ, 0, 0, 0, 0, 0, 0);
    send_beat(vna_pkg::ACT_READ, 1, 0, 0, 0, 0, 0);
    idle_gap(1);
  endtask

  // Random meshes: mostly valid triangles and reads over written vertices.
  task automatic test_random(input int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pace();
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        send_beat(vna_pkg::ACT_WRITE, $urandom_range(0, DEPTH - 1), $urandom, $urandom,
                  rnd_pos(), rnd_pos(), rnd_pos());
      end else if (pick < 60) begin
        send_beat(vna_pkg::ACT_ADD, rnd_written(), rnd_written(), rnd_written(),
                  vna_pkg::POS_W'($urandom), vna_pkg::POS_W'($urandom),
                  vna_pkg::POS_W'($urandom));
      end else if (pick < 67) begin
        send_beat(vna_pkg::ACT_CLEAR, $urandom_range(0, DEPTH - 1), $urandom, $urandom,
                  vna_pkg::POS_W'($urandom), 0, 0);
      end else begin
        send_beat(vna_pkg::ACT_READ, $urandom_range(0, 3) == 0 ? $urandom_range(0, DEPTH - 1)
                                                               : rnd_written(),
                  $urandom, $urandom, vna_pkg::POS_W'($urandom), vna_pkg::POS_W'($urandom),
                  vna_pkg::POS_W'($urandom));
      end
    end
    idle_gap(1);
  endtask

  // Long receiver hold-off while reads keep coming.
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 12; i++) send_beat(vna_pkg::ACT_READ, rnd_written(), 0, 0, 0, 0, 0);
    join
    idle_gap(1);
  endtask

  initial begin
    for (int k = 0; k < DEPTH; k++) begin
      acc_mem[k] = '{0, 0, 0};
      pos_mem[k] = '{0, 0, 0};
      written[k] = 1'b0;
    end
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_saturation();
    // Seed every sixteenth vertex with a position so random triangles have material.
    for (int k = 0; k < 64; k++) begin
      send_beat(vna_pkg::ACT_WRITE, k * 16, 0, 0, rnd_pos(), rnd_pos(), rnd_pos());
    end
    test_random(300);
    test_backpressure();
    test_random(400);
    while (normals_due.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (errors == 0) $display("** vertex_normal_accumulator_unit: PASSED **");
    else $display("** vertex_normal_accumulator_unit: FAILED **");
    $finish;
  end

endmodule

>>> sim.f
src/vna_pkg.sv
src/vertex_normal_accumulator_unit.sv
sim/vertex_normal_accumulator_unit_tb.sv
